// ===== sv/slfc_pkg.sv =====
// ----------------------------------------------------------------------------
// slfc_pkg
// Shared types and constants of the sync-word length-prefixed frame checker.
// ----------------------------------------------------------------------------
package slfc_pkg;

    localparam int REF_DEPTH_DEF   = 4096;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam logic [7:0]  SYNC0         = 8'hAA;
    localparam logic [7:0]  SYNC1         = 8'h55;
    localparam logic [12:0] REF_LEN_RST   = 13'd0;
    localparam logic [15:0] PAY_LIMIT_RST = 16'd4096;
    localparam logic [7:0]  ECHO_CMD_RST  = 8'h02;

    localparam logic [1:0] CFG_REF_LEN   = 2'd0;
    localparam logic [1:0] CFG_PAY_LIMIT = 2'd1;
    localparam logic [1:0] CFG_ECHO_CMD  = 2'd2;

    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_REF_WR  = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    localparam int C_ECHOED = 0;
    localparam int C_MATCH  = 1;
    localparam int C_MISM   = 2;
    localparam int C_EXTRA  = 3;
    localparam int C_ECHOF  = 4;
    localparam int C_OTHERF = 5;
    localparam int C_INVAL  = 6;
    localparam int C_DROP   = 7;
    localparam int C_NUM    = 8;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HELD,
        PH_CMD,
        PH_LLO,
        PH_LHI,
        PH_PAY
    } phase_t;

    // work handed from the parser stage to the tally stage
    typedef struct packed {
        logic        restart;
        logic        cmp;
        logic        extra;
        logic [7:0]  actual;
        logic        echo_commit;
        logic [15:0] pay_len;
        logic        other_inc;
        logic        inval_inc;
        logic [2:0]  drop_amt;
    } stage_t;

endpackage

// ===== sv/sync_length_frame_checker_top.sv =====
// ----------------------------------------------------------------------------
// sync_length_frame_checker_top
// Sync-word, length-prefixed frame checker with reference compare.
// ----------------------------------------------------------------------------
// Takes one item per cycle while s_tready is high and returns one stats snapshot
// per item. The item passes a parser stage that also reads the reference store,
// then a tally stage holding the counters, whose registers present its snapshot
// once the tally stage takes it. The input is held off only while both stages
// are full and the snapshot is not taken, and s_tready follows m_tready in the
// same cycle. A rejected header is replayed through the hunt within the same
// cycle. The reference store has no clearing pass.
module sync_length_frame_checker_top #(
    parameter int REF_DEPTH   = slfc_pkg::REF_DEPTH_DEF,
    parameter int COUNT_WIDTH = slfc_pkg::COUNT_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,  // data_byte, ref_index, zero pad
    input  logic [1:0]   s_tuser,  // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [311:0] m_tdata   // echoed_total, matched_count, mismatched_count,
                                   // extra_count, echo_frames, other_frames,
                                   // invalid_frames, dropped_bytes, mismatch_seen,
                                   // first mismatch offset, expected byte,
                                   // received byte, zero pad
);
    import slfc_pkg::*;

    localparam int AW = $clog2(REF_DEPTH);

    logic [12:0] ref_len_reg;
    logic [15:0] limit_reg;
    logic [7:0]  echo_cmd_reg;

    logic          accept, take, p1_valid;
    logic          mem_en, mem_we;
    logic [AW-1:0] mem_addr, p1_index;
    logic [7:0]    mem_wdata, mem_rdata;
    stage_t        p1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_len_reg  <= REF_LEN_RST;
            limit_reg    <= PAY_LIMIT_RST;
            echo_cmd_reg <= ECHO_CMD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_REF_LEN:   ref_len_reg  <= cfg_data[12:0];
                CFG_PAY_LIMIT: limit_reg    <= cfg_data;
                CFG_ECHO_CMD:  echo_cmd_reg <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    assign take     = p1_valid && (!m_tvalid || m_tready);
    assign s_tready = !p1_valid || take;
    assign accept   = s_tvalid && s_tready;

    slfc_parser #(
        .REF_DEPTH   (REF_DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_parser (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .take             (take),
        .kind             (s_tuser),
        .data_byte        (s_tdata[7:0]),
        .ref_index        (s_tdata[19:8]),
        .reference_length (ref_len_reg),
        .payload_limit    (limit_reg),
        .echo_command     (echo_cmd_reg),
        .mem_en           (mem_en),
        .mem_we           (mem_we),
        .mem_addr         (mem_addr),
        .mem_wdata        (mem_wdata),
        .p1_valid         (p1_valid),
        .p1               (p1),
        .p1_index         (p1_index)
    );

    slfc_ref_mem #(
        .REF_DEPTH (REF_DEPTH)
    ) u_mem (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    slfc_tally #(
        .REF_DEPTH   (REF_DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_tally (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .m_tready (m_tready),
        .p1       (p1),
        .p1_index (p1_index),
        .ref_byte (mem_rdata),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );
endmodule

// ===== sv/slfc_ref_mem.sv =====
// ----------------------------------------------------------------------------
// slfc_ref_mem
// Reference byte store: single port, registered read data.
// ----------------------------------------------------------------------------
module slfc_ref_mem #(
    parameter int REF_DEPTH = slfc_pkg::REF_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic                         we,
    input  logic [$clog2(REF_DEPTH)-1:0] addr,
    input  logic [7:0]                   wdata,
    output logic [7:0]                   rdata
);
    logic [7:0] mem [REF_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en && we)
        begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && !we)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== sv/slfc_parser.sv =====
// ----------------------------------------------------------------------------
// slfc_parser
// Header hunt, length check with replay, payload offset and reference read.
// ----------------------------------------------------------------------------
module slfc_parser #(
    parameter int REF_DEPTH   = slfc_pkg::REF_DEPTH_DEF,
    parameter int COUNT_WIDTH = slfc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic                         take,
    input  logic [1:0]                   kind,
    input  logic [7:0]                   data_byte,
    input  logic [11:0]                  ref_index,
    input  logic [12:0]                  reference_length,
    input  logic [15:0]                  payload_limit,
    input  logic [7:0]                   echo_command,
    output logic                         mem_en,
    output logic                         mem_we,
    output logic [$clog2(REF_DEPTH)-1:0] mem_addr,
    output logic [7:0]                   mem_wdata,
    output logic                         p1_valid,
    output slfc_pkg::stage_t             p1,
    output logic [$clog2(REF_DEPTH)-1:0] p1_index
);
    import slfc_pkg::*;

    localparam int AW  = $clog2(REF_DEPTH);
    localparam int CW  = COUNT_WIDTH;
    localparam int XW  = (AW > 12) ? AW : 12;
    localparam int DW0 = (CW + 1 > AW + 1) ? CW + 1 : AW + 1;
    localparam int DW  = (DW0 > 13) ? DW0 : 13;

    phase_t      phase_reg, phase_next;
    logic [7:0]  held_reg, held_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [7:0]  lo_reg, lo_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] len_reg, len_next;
    logic        echo_reg, echo_next;
    logic [CW-1:0] base_reg, base_next;
    logic        valid_reg, valid_next;
    stage_t      p1_reg, p1_next;
    logic [AW-1:0] idx_reg, idx_next;

    logic [15:0]   hdr_len;
    logic [XW-1:0] wr_idx;
    logic [DW-1:0] off_w, eff_w;
    logic [CW:0]   base_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            held_reg  <= '0;
            cmd_reg   <= '0;
            lo_reg    <= '0;
            rem_reg   <= '0;
            pos_reg   <= '0;
            len_reg   <= '0;
            echo_reg  <= 1'b0;
            base_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            cmd_reg   <= cmd_next;
            lo_reg    <= lo_next;
            rem_reg   <= rem_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            echo_reg  <= echo_next;
            base_reg  <= base_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_reg  <= p1_next;
            idx_reg <= idx_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        cmd_next   = cmd_reg;
        lo_next    = lo_reg;
        rem_next   = rem_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        echo_next  = echo_reg;
        base_next  = base_reg;
        p1_next    = '0;
        p1_next.actual  = data_byte;
        p1_next.pay_len = len_reg;
        hdr_len    = {data_byte, lo_reg};
        wr_idx     = XW'(ref_index);
        off_w      = DW'(base_reg) + DW'(pos_reg);
        eff_w      = (DW'(reference_length) > DW'(REF_DEPTH)) ? DW'(REF_DEPTH)
                                                              : DW'(reference_length);
        base_sum   = {1'b0, base_reg} + (CW + 1)'(len_reg);
        idx_next   = off_w[AW-1:0];
        mem_en     = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = off_w[AW-1:0];
        mem_wdata  = data_byte;

        if (valid_reg && take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end

        if (accept)
        begin
            valid_next = 1'b1;
            case (kind)
                KIND_RESTART:
                begin
                    p1_next.restart = 1'b1;
                    phase_next = PH_IDLE;
                    held_next  = '0;
                    cmd_next   = '0;
                    lo_next    = '0;
                    rem_next   = '0;
                    pos_next   = '0;
                    len_next   = '0;
                    echo_next  = 1'b0;
                    base_next  = '0;
                end
                KIND_REF_WR:
                begin
                    mem_addr = wr_idx[AW-1:0];
                    if ({1'b0, wr_idx} < (XW + 1)'(REF_DEPTH))
                    begin
                        mem_en = 1'b1;
                        mem_we = 1'b1;
                    end
                end
                KIND_BYTE:
                begin
                    case (phase_reg)
                        PH_IDLE:
                        begin
                            held_next  = data_byte;
                            phase_next = PH_HELD;
                        end
                        PH_HELD:
                        begin
                            if (held_reg == SYNC0 && data_byte == SYNC1)
                            begin
                                phase_next = PH_CMD;
                            end
                            else
                            begin
                                p1_next.drop_amt = 3'd1;
                                held_next = data_byte;
                            end
                        end
                        PH_CMD:
                        begin
                            cmd_next   = data_byte;
                            phase_next = PH_LLO;
                        end
                        PH_LLO:
                        begin
                            lo_next    = data_byte;
                            phase_next = PH_LHI;
                        end
                        PH_LHI:
                        begin
                            if (hdr_len > payload_limit)
                            begin
                                // rejected: drop the sync word, rehunt cmd, lo, hi
                                p1_next.inval_inc = 1'b1;
                                if (cmd_reg == SYNC0 && lo_reg == SYNC1)
                                begin
                                    p1_next.drop_amt = 3'd2;
                                    cmd_next   = data_byte;
                                    phase_next = PH_LLO;
                                end
                                else if (lo_reg == SYNC0 && data_byte == SYNC1)
                                begin
                                    p1_next.drop_amt = 3'd3;
                                    phase_next = PH_CMD;
                                end
                                else
                                begin
                                    p1_next.drop_amt = 3'd4;
                                    held_next  = data_byte;
                                    phase_next = PH_HELD;
                                end
                            end
                            else
                            begin
                                echo_next = (cmd_reg == echo_command);
                                if (hdr_len == 16'd0)
                                begin
                                    p1_next.other_inc = (cmd_reg != echo_command);
                                    phase_next = PH_IDLE;
                                end
                                else
                                begin
                                    len_next   = hdr_len;
                                    rem_next   = hdr_len;
                                    pos_next   = '0;
                                    phase_next = PH_PAY;
                                end
                            end
                        end
                        PH_PAY:
                        begin
                            if (echo_reg)
                            begin
                                if (off_w < eff_w)
                                begin
                                    p1_next.cmp = 1'b1;
                                    mem_en = 1'b1;
                                end
                                else
                                begin
                                    p1_next.extra = 1'b1;
                                end
                            end
                            rem_next = rem_reg - 16'd1;
                            pos_next = pos_reg + 16'd1;
                            if (rem_reg == 16'd1)
                            begin
                                phase_next = PH_IDLE;
                                if (echo_reg)
                                begin
                                    p1_next.echo_commit = 1'b1;
                                    base_next = base_sum[CW] ? '1 : base_sum[CW-1:0];
                                end
                                else
                                begin
                                    p1_next.other_inc = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    assign p1_valid = valid_reg;
    assign p1       = p1_reg;
    assign p1_index = idx_reg;
endmodule

// ===== sv/slfc_tally.sv =====
// ----------------------------------------------------------------------------
// slfc_tally
// Payload compare, per-frame tallies, saturating committed counters, snapshot.
// ----------------------------------------------------------------------------
module slfc_tally #(
    parameter int REF_DEPTH   = slfc_pkg::REF_DEPTH_DEF,
    parameter int COUNT_WIDTH = slfc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         take,
    input  logic                         m_tready,
    input  slfc_pkg::stage_t             p1,
    input  logic [$clog2(REF_DEPTH)-1:0] p1_index,
    input  logic [7:0]                   ref_byte,
    output logic                         m_tvalid,
    output logic [311:0]                 m_tdata
);
    import slfc_pkg::*;

    localparam int CW = COUNT_WIDTH;
    localparam int AW = $clog2(REF_DEPTH);

    logic [CW-1:0] cnt_reg [C_NUM];
    logic [CW-1:0] cnt_next [C_NUM];
    logic [15:0]   ftm_reg, ftm_next, ftx_reg, ftx_next, fte_reg, fte_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] pidx_reg, pidx_next;
    logic [7:0]    pexp_reg, pexp_next, pact_reg, pact_next;
    logic          seen_reg, seen_next;
    logic [AW-1:0] fidx_reg, fidx_next;
    logic [7:0]    fexp_reg, fexp_next, fact_reg, fact_next;
    logic          mv_reg, mv_next;
    logic          hit, miss;

    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] cur,
                                              input logic [15:0] amt);
        logic [CW:0] sum;
        sum = {1'b0, cur} + (CW + 1)'(amt);
        return sum[CW] ? {CW{1'b1}} : sum[CW-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < C_NUM; i++)
            begin
                cnt_reg[i] <= '0;
            end
            ftm_reg  <= '0;
            ftx_reg  <= '0;
            fte_reg  <= '0;
            pend_reg <= 1'b0;
            pidx_reg <= '0;
            pexp_reg <= '0;
            pact_reg <= '0;
            seen_reg <= 1'b0;
            fidx_reg <= '0;
            fexp_reg <= '0;
            fact_reg <= '0;
            mv_reg   <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < C_NUM; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
            ftm_reg  <= ftm_next;
            ftx_reg  <= ftx_next;
            fte_reg  <= fte_next;
            pend_reg <= pend_next;
            pidx_reg <= pidx_next;
            pexp_reg <= pexp_next;
            pact_reg <= pact_next;
            seen_reg <= seen_next;
            fidx_reg <= fidx_next;
            fexp_reg <= fexp_next;
            fact_reg <= fact_next;
            mv_reg   <= mv_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < C_NUM; i++)
        begin
            cnt_next[i] = cnt_reg[i];
        end
        ftm_next  = ftm_reg;
        ftx_next  = ftx_reg;
        fte_next  = fte_reg;
        pend_next = pend_reg;
        pidx_next = pidx_reg;
        pexp_next = pexp_reg;
        pact_next = pact_reg;
        seen_next = seen_reg;
        fidx_next = fidx_reg;
        fexp_next = fexp_reg;
        fact_next = fact_reg;
        mv_next   = mv_reg && !m_tready;
        hit  = p1.cmp && (ref_byte == p1.actual);
        miss = p1.cmp && (ref_byte != p1.actual);

        if (take)
        begin
            mv_next = 1'b1;
            if (p1.restart)
            begin
                for (int i = 0; i < C_NUM; i++)
                begin
                    cnt_next[i] = '0;
                end
                ftm_next  = '0;
                ftx_next  = '0;
                fte_next  = '0;
                pend_next = 1'b0;
                pidx_next = '0;
                pexp_next = '0;
                pact_next = '0;
                seen_next = 1'b0;
                fidx_next = '0;
                fexp_next = '0;
                fact_next = '0;
            end
            else
            begin
                ftm_next = ftm_reg + {15'd0, hit};
                ftx_next = ftx_reg + {15'd0, miss};
                fte_next = fte_reg + {15'd0, p1.extra};
                if (miss && !pend_reg)
                begin
                    pend_next = 1'b1;
                    pidx_next = p1_index;
                    pexp_next = ref_byte;
                    pact_next = p1.actual;
                end
                if (p1.echo_commit)
                begin
                    cnt_next[C_ECHOF]  = sat_add(cnt_reg[C_ECHOF], 16'd1);
                    cnt_next[C_ECHOED] = sat_add(cnt_reg[C_ECHOED], p1.pay_len);
                    cnt_next[C_MATCH]  = sat_add(cnt_reg[C_MATCH], ftm_next);
                    cnt_next[C_MISM]   = sat_add(cnt_reg[C_MISM], ftx_next);
                    cnt_next[C_EXTRA]  = sat_add(cnt_reg[C_EXTRA], fte_next);
                    if (pend_next && !seen_reg)
                    begin
                        seen_next = 1'b1;
                        fidx_next = pidx_next;
                        fexp_next = pexp_next;
                        fact_next = pact_next;
                    end
                    ftm_next  = '0;
                    ftx_next  = '0;
                    fte_next  = '0;
                    pend_next = 1'b0;
                end
                if (p1.other_inc)
                begin
                    cnt_next[C_OTHERF] = sat_add(cnt_reg[C_OTHERF], 16'd1);
                end
                if (p1.inval_inc)
                begin
                    cnt_next[C_INVAL] = sat_add(cnt_reg[C_INVAL], 16'd1);
                end
                cnt_next[C_DROP] = sat_add(cnt_reg[C_DROP], {13'd0, p1.drop_amt});
            end
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {7'd0,
                       fact_reg,
                       fexp_reg,
                       32'(fidx_reg),
                       seen_reg,
                       32'(cnt_reg[C_DROP]),
                       32'(cnt_reg[C_INVAL]),
                       32'(cnt_reg[C_OTHERF]),
                       32'(cnt_reg[C_ECHOF]),
                       32'(cnt_reg[C_EXTRA]),
                       32'(cnt_reg[C_MISM]),
                       32'(cnt_reg[C_MATCH]),
                       32'(cnt_reg[C_ECHOED])};

`ifndef SYNTHESIS
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        take && p1.restart |=> !seen_reg && cnt_reg[C_ECHOED] == '0 && cnt_reg[C_DROP] == '0)
        else $error("restart did not clear the tallies");

    a_seen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(seen_reg) |-> $past(take && p1.restart))
        else $error("first mismatch record lost without restart");

    a_cmp_xor_extra: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> !(p1.cmp && p1.extra))
        else $error("payload byte both compared and extra");

    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        take && !p1.restart && p1.echo_commit |=> ftm_reg == '0 && !pend_reg)
        else $error("frame tallies not cleared at commit");
`endif
endmodule
